// ===== src/source_tokenizer_defines.svh =====
// Assertion helpers shared by the tokenizer modules.
// Each expects clk and rst_n in the scope where it is used.
`ifndef SOURCE_TOKENIZER_DEFINES_SVH
`define SOURCE_TOKENIZER_DEFINES_SVH

// Same-cycle implication.
`define STOK_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stok assertion failed");

// Next-cycle implication.
`define STOK_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stok assertion failed");

`endif

// ===== src/stok_pkg.sv =====
package stok_pkg;

    localparam int MAX_TOKEN_BYTES_DEF = 62;
    localparam int BYTE_W              = 8;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // What the one-byte result register is loaded with.
    typedef enum logic [1:0] {
        SGL_BYTE,
        SGL_COLON,
        SGL_EMPTY
    } sgl_kind_t;

    typedef struct packed {
        logic      store;
        logic      set_quote;
        logic      esc_set;
        logic      esc_clr;
        logic      load_single;
        sgl_kind_t sgl_kind;
        logic      load_body;
        logic      body_label;
        logic      rd_en;
        logic      idx_inc;
        logic      clear;
        logic      sel_body;
    } dp_cmd_t;

    typedef struct packed {
        logic is_space;
        logic is_single;
        logic is_colon;
        logic is_quote;
        logic is_hash;
        logic is_bslash;
        logic is_newline;
        logic is_close;
        logic esc;
        logic body_last;
    } dp_status_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL);
    endfunction

    function automatic logic is_single(input logic [7:0] b);
        return (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_LBRACE) ||
               (b == CH_RBRACE) || (b == CH_LBRACK) || (b == CH_RBRACK) ||
               (b == CH_COMMA)  || (b == CH_SEMI);
    endfunction

endpackage

// ===== src/source_tokenizer.sv =====
// Source tokenizer: source bytes enter one word at a time on the input
// channel (src_byte, end_of_input) and tokens leave as runs of output words,
// one token byte per word, with tok_last on the final byte. Blanks are
// skipped; ( ) { } [ ] , ; are one-byte tokens; quoted strings keep their
// opening quote and drop the closing one, with backslash escapes kept;
// a # comment yields one empty token (tok_empty, byte 0); any other run is a
// word, and a word closed by a colon comes out as a label with the colon
// first. end_of_input flushes an open token. Tokens longer than
// MAX_TOKEN_BYTES are cut and flagged with tok_truncated on every byte.
// An input word that only adds to or skips a token stalls nothing. A word
// that closes a token holds the input stalled while the token drains: the
// one-byte result (colon, empty token or one-byte token) and each stored
// byte, which is read from the token RAM, then presented from the RAM's
// output register; output stalls hold the drain. The token RAM is not
// cleared after reset; only bytes written for the current token are read.

module source_tokenizer #(
    parameter int MAX_TOKEN_BYTES = stok_pkg::MAX_TOKEN_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // byte input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] src_byte,
    input  logic       end_of_input,
    // token output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] tok_byte,
    output logic       tok_last,
    output logic       tok_empty,
    output logic       tok_truncated
);
    import stok_pkg::*;

    // controller to datapath commands, datapath flags back
    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: scan mode and the drain of one token
    stok_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .end_of_input (end_of_input),
        .out_stall    (out_stall),
        .status       (status),
        .in_stall     (in_stall),
        .out_valid    (out_valid),
        .cmd          (cmd)
    );

    // byte classes, token RAM, counters and the output mux
    stok_datapath #(
        .MAX_TOKEN_BYTES (MAX_TOKEN_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_byte      (src_byte),
        .cmd           (cmd),
        .status        (status),
        .tok_byte      (tok_byte),
        .tok_last      (tok_last),
        .tok_empty     (tok_empty),
        .tok_truncated (tok_truncated)
    );

endmodule

// ===== src/stok_ram.sv =====
module stok_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 62
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/stok_datapath.sv =====
`include "source_tokenizer_defines.svh"

module stok_datapath #(
    parameter int MAX_TOKEN_BYTES = stok_pkg::MAX_TOKEN_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           src_byte,
    input  stok_pkg::dp_cmd_t    cmd,
    output stok_pkg::dp_status_t status,
    output logic [7:0]           tok_byte,
    output logic                 tok_last,
    output logic                 tok_empty,
    output logic                 tok_truncated
);
    import stok_pkg::*;

    localparam int CNT_W  = $clog2(MAX_TOKEN_BYTES + 1);
    localparam int ADDR_W = $clog2(MAX_TOKEN_BYTES);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TOKEN_BYTES);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             esc_reg, esc_next;
    logic             qdbl_reg, qdbl_next;

    logic [CNT_W-1:0] body_n_reg, body_n_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             trunc_reg, trunc_next;
    logic [7:0]       sgl_byte_reg, sgl_byte_next;
    logic             sgl_last_reg, sgl_last_next;
    logic             sgl_empty_reg, sgl_empty_next;
    logic             sgl_trunc_reg, sgl_trunc_next;

    logic             full;
    logic [CNT_W-1:0] lbl_n;
    logic             lbl_trunc;
    logic [7:0]       ram_rdata;
    logic             body_last;

    assign full      = (cnt_reg == CNT_MAX);
    // a label keeps room for its colon
    assign lbl_n     = full ? (CNT_MAX - CNT_ONE) : cnt_reg;
    assign lbl_trunc = ovf_reg | full;
    assign body_last = ((idx_reg + CNT_ONE) == body_n_reg);

    stok_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_TOKEN_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (cmd.store && !full),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (src_byte),
        .re    (cmd.rd_en),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        esc_next  = esc_reg;
        qdbl_next = qdbl_reg;
        if (cmd.store)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_ONE;
            end
        end
        if (cmd.esc_set)
        begin
            esc_next = 1'b1;
        end
        if (cmd.esc_clr)
        begin
            esc_next = 1'b0;
        end
        if (cmd.set_quote)
        begin
            qdbl_next = (src_byte == CH_DQUOTE);
        end
        if (cmd.clear)
        begin
            cnt_next = '0;
            ovf_next = 1'b0;
            esc_next = 1'b0;
        end
    end

    always_comb
    begin
        body_n_next    = body_n_reg;
        idx_next       = idx_reg;
        trunc_next     = trunc_reg;
        sgl_byte_next  = sgl_byte_reg;
        sgl_last_next  = sgl_last_reg;
        sgl_empty_next = sgl_empty_reg;
        sgl_trunc_next = sgl_trunc_reg;
        if (cmd.load_body)
        begin
            body_n_next = cmd.body_label ? lbl_n : cnt_reg;
            trunc_next  = cmd.body_label ? lbl_trunc : ovf_reg;
            idx_next    = '0;
        end
        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CNT_ONE;
        end
        if (cmd.load_single)
        begin
            unique case (cmd.sgl_kind)
                SGL_BYTE:
                begin
                    sgl_byte_next  = src_byte;
                    sgl_last_next  = 1'b1;
                    sgl_empty_next = 1'b0;
                    sgl_trunc_next = 1'b0;
                end
                SGL_COLON:
                begin
                    sgl_byte_next  = CH_COLON;
                    sgl_last_next  = (lbl_n == '0);
                    sgl_empty_next = 1'b0;
                    sgl_trunc_next = lbl_trunc;
                end
                SGL_EMPTY:
                begin
                    sgl_byte_next  = CH_NUL;
                    sgl_last_next  = 1'b1;
                    sgl_empty_next = 1'b1;
                    sgl_trunc_next = 1'b0;
                end
                default:
                begin
                    sgl_byte_next  = CH_NUL;
                    sgl_last_next  = 1'b1;
                    sgl_empty_next = 1'b1;
                    sgl_trunc_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            esc_reg  <= 1'b0;
            qdbl_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
            esc_reg  <= esc_next;
            qdbl_reg <= qdbl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        body_n_reg    <= body_n_next;
        idx_reg       <= idx_next;
        trunc_reg     <= trunc_next;
        sgl_byte_reg  <= sgl_byte_next;
        sgl_last_reg  <= sgl_last_next;
        sgl_empty_reg <= sgl_empty_next;
        sgl_trunc_reg <= sgl_trunc_next;
    end

    always_comb
    begin
        status.is_space   = is_space(src_byte);
        status.is_single  = is_single(src_byte);
        status.is_colon   = (src_byte == CH_COLON);
        status.is_quote   = (src_byte == CH_SQUOTE) || (src_byte == CH_DQUOTE);
        status.is_hash    = (src_byte == CH_HASH);
        status.is_bslash  = (src_byte == CH_BSLASH);
        status.is_newline = (src_byte == CH_NL);
        status.is_close   = (src_byte == (qdbl_reg ? CH_DQUOTE : CH_SQUOTE));
        status.esc        = esc_reg;
        status.body_last  = body_last;
    end

    assign tok_byte      = cmd.sel_body ? ram_rdata : sgl_byte_reg;
    assign tok_last      = cmd.sel_body ? body_last : sgl_last_reg;
    assign tok_empty     = cmd.sel_body ? 1'b0      : sgl_empty_reg;
    assign tok_truncated = cmd.sel_body ? trunc_reg : sgl_trunc_reg;

    `STOK_ASSERT_IMP(a_ovf_only_when_full, ovf_reg, cnt_reg == CNT_MAX)
    `STOK_ASSERT_NXT(a_store_full_sets_ovf, cmd.store && full && !cmd.clear, ovf_reg)

endmodule

// ===== src/stok_ctrl.sv =====
`include "source_tokenizer_defines.svh"

module stok_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 end_of_input,
    input  logic                 out_stall,
    input  stok_pkg::dp_status_t status,
    output logic                 in_stall,
    output logic                 out_valid,
    output stok_pkg::dp_cmd_t    cmd
);
    import stok_pkg::*;

    typedef enum logic [1:0] {
        PH_IN,
        PH_SINGLE,
        PH_RD,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        M_IDLE,
        M_WORD,
        M_STRING,
        M_COMMENT
    } mode_t;

    phase_t phase_reg, phase_next;
    mode_t  mode_reg, mode_next;
    logic   bodyp_reg, bodyp_next;  // body follows the one-byte result
    logic   tailp_reg, tailp_next;  // one-byte result follows the body

    logic in_acc;
    logic out_acc;
    logic ends_word;

    assign in_stall  = (phase_reg != PH_IN);
    assign out_valid = (phase_reg == PH_SINGLE) || (phase_reg == PH_BODY);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;
    assign ends_word = status.is_space || status.is_single || status.is_colon;

    always_comb
    begin
        cmd        = '0;
        phase_next = phase_reg;
        mode_next  = mode_reg;
        bodyp_next = bodyp_reg;
        tailp_next = tailp_reg;
        unique case (phase_reg)
            PH_IN:
            begin
                if (in_acc)
                begin
                    if (end_of_input)
                    begin
                        mode_next = M_IDLE;
                        unique case (mode_reg)
                            M_WORD, M_STRING:
                            begin
                                cmd.load_body = 1'b1;
                                phase_next    = PH_RD;
                            end
                            M_COMMENT:
                            begin
                                cmd.load_single = 1'b1;
                                cmd.sgl_kind    = SGL_EMPTY;
                                phase_next      = PH_SINGLE;
                            end
                            M_IDLE:
                            begin
                                phase_next = PH_IN;
                            end
                        endcase
                    end
                    else
                    begin
                        unique case (mode_reg)
                            M_WORD:
                            begin
                                priority if (!ends_word)
                                begin
                                    cmd.store = 1'b1;
                                end
                                else if (status.is_colon)
                                begin
                                    cmd.load_single = 1'b1;
                                    cmd.sgl_kind    = SGL_COLON;
                                    cmd.load_body   = 1'b1;
                                    cmd.body_label  = 1'b1;
                                    bodyp_next      = 1'b1;
                                    phase_next      = PH_SINGLE;
                                    mode_next       = M_IDLE;
                                end
                                else
                                begin
                                    cmd.load_body = 1'b1;
                                    phase_next    = PH_RD;
                                    mode_next     = M_IDLE;
                                    if (status.is_single)
                                    begin
                                        cmd.load_single = 1'b1;
                                        cmd.sgl_kind    = SGL_BYTE;
                                        tailp_next      = 1'b1;
                                    end
                                end
                            end
                            M_STRING:
                            begin
                                priority if (status.esc)
                                begin
                                    cmd.store   = 1'b1;
                                    cmd.esc_clr = 1'b1;
                                end
                                else if (status.is_bslash)
                                begin
                                    cmd.store   = 1'b1;
                                    cmd.esc_set = 1'b1;
                                end
                                else if (status.is_close)
                                begin
                                    cmd.load_body = 1'b1;
                                    phase_next    = PH_RD;
                                    mode_next     = M_IDLE;
                                end
                                else
                                begin
                                    cmd.store = 1'b1;
                                end
                            end
                            M_COMMENT:
                            begin
                                if (status.is_newline)
                                begin
                                    cmd.load_single = 1'b1;
                                    cmd.sgl_kind    = SGL_EMPTY;
                                    phase_next      = PH_SINGLE;
                                    mode_next       = M_IDLE;
                                end
                            end
                            M_IDLE:
                            begin
                                priority if (status.is_space)
                                begin
                                    mode_next = M_IDLE;
                                end
                                else if (status.is_single)
                                begin
                                    cmd.load_single = 1'b1;
                                    cmd.sgl_kind    = SGL_BYTE;
                                    phase_next      = PH_SINGLE;
                                end
                                else if (status.is_quote)
                                begin
                                    cmd.set_quote = 1'b1;
                                    cmd.store     = 1'b1;
                                    mode_next     = M_STRING;
                                end
                                else if (status.is_hash)
                                begin
                                    mode_next = M_COMMENT;
                                end
                                else if (status.is_colon)
                                begin
                                    // lone colon: label with no body
                                    cmd.load_single = 1'b1;
                                    cmd.sgl_kind    = SGL_COLON;
                                    phase_next      = PH_SINGLE;
                                end
                                else
                                begin
                                    cmd.store = 1'b1;
                                    mode_next = M_WORD;
                                end
                            end
                        endcase
                    end
                end
            end
            PH_SINGLE:
            begin
                if (out_acc)
                begin
                    if (bodyp_reg)
                    begin
                        bodyp_next = 1'b0;
                        phase_next = PH_RD;
                    end
                    else
                    begin
                        phase_next = PH_IN;
                    end
                end
            end
            PH_RD:
            begin
                cmd.rd_en  = 1'b1;
                phase_next = PH_BODY;
            end
            PH_BODY:
            begin
                cmd.sel_body = 1'b1;
                if (out_acc)
                begin
                    if (status.body_last)
                    begin
                        cmd.clear  = 1'b1;
                        tailp_next = 1'b0;
                        phase_next = tailp_reg ? PH_SINGLE : PH_IN;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        phase_next  = PH_RD;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IN;
            mode_reg  <= M_IDLE;
            bodyp_reg <= 1'b0;
            tailp_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
            bodyp_reg <= bodyp_next;
            tailp_reg <= tailp_next;
        end
    end

    `STOK_ASSERT_NXT(a_read_then_body, phase_reg == PH_RD, phase_reg == PH_BODY)
    `STOK_ASSERT_IMP(a_emit_mode_idle, out_valid, mode_reg == M_IDLE)
    `STOK_ASSERT_IMP(a_pending_exclusive, bodyp_reg, !tailp_reg && phase_reg == PH_SINGLE)

endmodule

// ===== tb/sv/token_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the tokenizer, predicts the token words of each
// accepted source word and compares them in order.
module token_checker #(
    parameter int MAX_BYTES = stok_pkg::MAX_TOKEN_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] src_byte,
    input  logic       end_of_input,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] tok_byte,
    input  logic       tok_last,
    input  logic       tok_empty,
    input  logic       tok_truncated,
    output int         errors,
    output int         pending
);
    import stok_pkg::*;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_WORD,
        SCAN_STRING,
        SCAN_COMMENT
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       empty;
        logic       trunc;
    } tok_word_t;

    tok_word_t   tok_q[$];
    tok_word_t   seen;
    scan_mode_t  mode;
    logic        esc;
    logic        dq;
    logic [7:0]  held [MAX_BYTES];
    int          count;
    logic        overflow;

    function automatic logic blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_NL;
    endfunction

    function automatic logic punct(input logic [7:0] b);
        return b == CH_LPAREN || b == CH_RPAREN || b == CH_LBRACE ||
               b == CH_RBRACE || b == CH_LBRACK || b == CH_RBRACK ||
               b == CH_COMMA  || b == CH_SEMI;
    endfunction

    function automatic void expect_word(input logic [7:0] b, input logic last,
                                        input logic empty, input logic trunc);
        tok_word_t w;
        w.b     = b;
        w.last  = last;
        w.empty = empty;
        w.trunc = trunc;
        tok_q.push_back(w);
    endfunction

    function automatic void clear_held();
        count    = 0;
        overflow = 1'b0;
        esc      = 1'b0;
    endfunction

    function automatic void keep_byte(input logic [7:0] b);
        if (count < MAX_BYTES)
        begin
            held[count] = b;
            count++;
        end
        else
            overflow = 1'b1;
    endfunction

    // Labels carry their colon inside the byte limit.
    function automatic void flush_held(input logic label);
        int   n;
        logic tr;
        n  = count;
        tr = overflow;
        if (label && n >= MAX_BYTES)
        begin
            n  = MAX_BYTES - 1;
            tr = 1'b1;
        end
        if (label)
            expect_word(CH_COLON, n == 0, 1'b0, tr);
        else if (n == 0)
            expect_word(CH_NUL, 1'b1, 1'b1, 1'b0);
        for (int i = 0; i < n; i++)
            expect_word(held[i], i + 1 == n, 1'b0, tr);
        clear_held();
        mode = SCAN_IDLE;
    endfunction

    function automatic void open_token(input logic [7:0] b);
        clear_held();
        if (blank(b))
            mode = SCAN_IDLE;
        else if (punct(b))
        begin
            expect_word(b, 1'b1, 1'b0, 1'b0);
            mode = SCAN_IDLE;
        end
        else if (b == CH_SQUOTE || b == CH_DQUOTE)
        begin
            dq = (b == CH_DQUOTE);
            keep_byte(b);
            mode = SCAN_STRING;
        end
        else if (b == CH_HASH)
            mode = SCAN_COMMENT;
        else if (b == CH_COLON)
            flush_held(1'b1);
        else
        begin
            keep_byte(b);
            mode = SCAN_WORD;
        end
    endfunction

    function automatic void predict_tokens(input logic [7:0] b, input logic eoi);
        if (eoi)
        begin
            if (mode == SCAN_WORD || mode == SCAN_STRING)
                flush_held(1'b0);
            else if (mode == SCAN_COMMENT)
                expect_word(CH_NUL, 1'b1, 1'b1, 1'b0);
            clear_held();
            mode = SCAN_IDLE;
        end
        else
        begin
            case (mode)
                SCAN_WORD:
                begin
                    if (!(blank(b) || punct(b) || b == CH_COLON))
                        keep_byte(b);
                    else if (b == CH_COLON)
                        flush_held(1'b1);
                    else
                    begin
                        flush_held(1'b0);
                        open_token(b);
                    end
                end
                SCAN_STRING:
                begin
                    if (esc)
                    begin
                        keep_byte(b);
                        esc = 1'b0;
                    end
                    else if (b == CH_BSLASH)
                    begin
                        keep_byte(b);
                        esc = 1'b1;
                    end
                    else if (b == (dq ? CH_DQUOTE : CH_SQUOTE))
                        flush_held(1'b0);
                    else
                        keep_byte(b);
                end
                SCAN_COMMENT:
                begin
                    if (b == CH_NL)
                    begin
                        expect_word(CH_NUL, 1'b1, 1'b1, 1'b0);
                        clear_held();
                        mode = SCAN_IDLE;
                    end
                end
                default:
                    open_token(b);
            endcase
        end
    endfunction

    // Sampled mid-cycle: what is seen here is what the next rising edge takes.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            mode = SCAN_IDLE;
            dq   = 1'b0;
            clear_held();
            tok_q.delete();
            errors = 0;
        end
        else
        begin
            if (in_valid === 1'b1 && in_stall === 1'b0)
                predict_tokens(src_byte, end_of_input);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (tok_q.size() == 0)
                begin
                    $error("unexpected token word: tok_byte %02h", tok_byte);
                    errors++;
                end
                else
                begin
                    seen = tok_q.pop_front();
                    if (tok_byte !== seen.b)
                    begin
                        $error("tok_byte: expected %02h, got %02h", seen.b, tok_byte);
                        errors++;
                    end
                    if (tok_last !== seen.last)
                    begin
                        $error("tok_last: expected %0b, got %0b", seen.last, tok_last);
                        errors++;
                    end
                    if (tok_empty !== seen.empty)
                    begin
                        $error("tok_empty: expected %0b, got %0b", seen.empty, tok_empty);
                        errors++;
                    end
                    if (tok_truncated !== seen.trunc)
                    begin
                        $error("tok_truncated: expected %0b, got %0b",
                               seen.trunc, tok_truncated);
                        errors++;
                    end
                end
            end
        end
        pending = tok_q.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

// Top of the tokenizer bench: clock, reset, source words and output stalls.
// All prediction and comparison lives in token_checker; this module only
// drives stimulus and reports the verdict from the checker's error count.
module tb;
    import stok_pkg::*;

    localparam int HALF_NS      = 6;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 200;
    // Last stretch of random words runs with no idling on either side.
    localparam int QUIET_TAIL   = 40;
    // Wait once nothing is pending, well past a one-byte token's drain.
    localparam int DRAIN_CYCLES = 200;
    // Worst case is about 63 token words per source word, each waiting out
    // the longest stall burst, over ~250 source words: ~3 ms. Allow several times.
    localparam int TIMEOUT_NS   = 20_000_000;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic [7:0] src_byte      = 8'h00;
    logic       end_of_input  = 1'b0;
    logic       out_stall     = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] tok_byte;
    logic       tok_last;
    logic       tok_empty;
    logic       tok_truncated;

    int errors;
    int pending;
    int items_sent = 0;
    // Percent chance that a word (sender) or a cycle (receiver) starts a gap.
    int idle_pct   = 0;
    int stall_left = 0;

    // One-byte tokens and blanks, used as separators between random tokens.
    logic [7:0] singles [8] = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
                                CH_LBRACK, CH_RBRACK, CH_COMMA, CH_SEMI};
    logic [7:0] blanks  [3] = '{CH_SPACE, CH_TAB, CH_NL};

    always #HALF_NS clk = ~clk;

    source_tokenizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .src_byte      (src_byte),
        .end_of_input  (end_of_input),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tok_byte      (tok_byte),
        .tok_last      (tok_last),
        .tok_empty     (tok_empty),
        .tok_truncated (tok_truncated)
    );

    token_checker tok_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .src_byte      (src_byte),
        .end_of_input  (end_of_input),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tok_byte      (tok_byte),
        .tok_last      (tok_last),
        .tok_empty     (tok_empty),
        .tok_truncated (tok_truncated),
        .errors        (errors),
        .pending       (pending)
    );

    // Receiver side: random stall bursts, rate set by idle_pct.
    always @(posedge clk)
    begin
        if (!rst_n || idle_pct == 0)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < idle_pct)
        begin
            stall_left = $urandom_range(1, 13) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Present one source word and hold it until taken. Acceptance is read
    // mid-cycle, where in_stall is settled for the coming edge. Returns at
    // the edge that took the word.
    task automatic send(input logic [7:0] b, input logic eoi);
        logic taken;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        src_byte     <= b;
        end_of_input <= eoi;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = (in_stall === 1'b0);
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Source byte is don't-care with the end flag set; randomize it anyway.
    task automatic send_eoi();
        send(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send(s[i], 1'b0);
    endtask

    // Mostly letters; now and then any byte, which may end the word early.
    function automatic logic [7:0] word_byte();
        if ($urandom_range(0, 3) != 0)
            return "a" + 8'($urandom_range(0, 25));
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly short tokens; a few cross the 62-byte store to hit truncation.
    function automatic int token_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(58, 70);
        return $urandom_range(1, 8);
    endfunction

    task automatic send_word_body();
        int len;
        int i;
        len = token_len();
        send("a" + 8'($urandom_range(0, 25)), 1'b0);
        for (i = 1; i < len; i++)
            send(word_byte(), 1'b0);
    endtask

    // One random token, usually well formed; some are left open or mangled
    // so that the following words land in an odd state.
    task automatic rand_token();
        int         len;
        int         i;
        logic [7:0] q;
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0, 1, 2, 3:
            begin
                send_word_body();
                case ($urandom_range(0, 3))
                    0, 1: send(blanks[$urandom_range(0, 2)], 1'b0);
                    2:    send(singles[$urandom_range(0, 7)], 1'b0);
                    default: ;
                endcase
            end
            4:
            begin
                // label: word closed by a colon
                send_word_body();
                send(CH_COLON, 1'b0);
            end
            5, 6:
            begin
                q   = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                len = token_len();
                send(q, 1'b0);
                for (i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        // escaped byte, may be the quote itself
                        send(CH_BSLASH, 1'b0);
                        send(8'($urandom_range(0, 255)), 1'b0);
                    end
                    else
                    begin
                        b = 8'($urandom_range(0, 255));
                        if (b == q || b == CH_BSLASH)
                            b = "s";
                        send(b, 1'b0);
                    end
                end
                if ($urandom_range(0, 7) != 0)
                    send(q, 1'b0);
            end
            7:
            begin
                send(CH_HASH, 1'b0);
                repeat ($urandom_range(0, 5))
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CH_NL)
                        b = "c";
                    send(b, 1'b0);
                end
                if ($urandom_range(0, 7) != 0)
                    send(CH_NL, 1'b0);
            end
            8:  send(singles[$urandom_range(0, 7)], 1'b0);
            9:  send(blanks[$urandom_range(0, 2)], 1'b0);
            10:
            begin
                // noise: raw bytes of any value, or an early end of input
                if ($urandom_range(0, 2) == 0)
                    send_eoi();
                else
                    repeat ($urandom_range(1, 3))
                        send(8'($urandom_range(0, 255)), 1'b0);
            end
            default: send(CH_COLON, 1'b0);
        endcase
    endtask

    initial
    begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int start_cnt;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: every one-byte token, a label, a lone colon,
        // quote and hash inside a word, zero and all-ones bytes in a word,
        // a string with an escaped quote, a comment, a flushed word, and an
        // end of input with nothing open.
        send_text("(){}[],;");
        send_text("ab:");
        send_text(":");
        send_text("q'#\t");
        send(CH_NUL, 1'b0);
        send(8'hFF, 1'b0);
        send_text(" ");
        send_text("\"\\\"\"");
        send_text("#c\n");
        send_text("w");
        send_eoi();
        send_eoi();

        // Random tokens with shifting idle rates, then a quiet tail.
        start_cnt = items_sent;
        while (items_sent - start_cnt < RANDOM_ITEMS)
        begin
            if (items_sent - start_cnt >= RANDOM_ITEMS - QUIET_TAIL)
                idle_pct = 0;
            else if ($urandom_range(0, 5) == 0)
                case ($urandom_range(0, 3))
                    0: idle_pct = 0;
                    1: idle_pct = 8;
                    2: idle_pct = 20;
                    default: idle_pct = 35;
                endcase
            rand_token();
        end
        // Flush whatever is still open, then drop valid.
        send_eoi();
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
